@@ rtl/irps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// irps_pkg: shared types and constants for the ir pulse/space run decoder
// no dependencies; used by irps_lane, irps_merge, the top level and the testbench

package irps_pkg;

    localparam int RUN_BYTES    = 4;
    localparam int BYTE_BITS    = 8;
    localparam int COUNT_BITS   = 7;
    localparam int LEN_BITS     = 7;
    localparam int RUN_DUR_BITS = COUNT_BITS + BYTE_BITS;
    localparam int OUT_DUR_BITS = 24;
    localparam int CFG_IDX_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TIME_UNIT = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEADER    = 8'd1;

    localparam logic [BYTE_BITS-1:0] TIME_UNIT_RESET = 8'd50;
    localparam logic [BYTE_BITS-1:0] HEADER_RESET    = 8'h84;

    typedef struct packed {
        logic                 status_ok;
        logic [LEN_BITS-1:0]  packet_length;
        logic [BYTE_BITS-1:0] byte0;
        logic [BYTE_BITS-1:0] byte1;
        logic [BYTE_BITS-1:0] byte2;
        logic [BYTE_BITS-1:0] byte3;
        logic [BYTE_BITS-1:0] byte4;
    } t_in_item;

    typedef struct packed {
        logic [OUT_DUR_BITS-1:0] duration;
        logic                    is_pulse;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic                    kind;
        logic                    nz;
        logic [RUN_DUR_BITS-1:0] dur;
    } t_run;

    typedef struct packed {
        logic done;
        logic at_first;
    } t_merge_stat;

endpackage

`default_nettype wire

@@ rtl/irps_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// irps_lane: one run lane, scales a run byte count by the time unit
// depends on irps_pkg

module irps_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_load,
    input  wire logic [irps_pkg::BYTE_BITS-1:0] i_run_byte,
    input  wire logic [irps_pkg::BYTE_BITS-1:0] i_time_unit,
    output irps_pkg::t_run                     o_run
);
    import irps_pkg::*;

    t_run                    r_run;
    t_run                    n_run;
    logic [RUN_DUR_BITS-1:0] prod;

    always_comb begin
        prod       = RUN_DUR_BITS'(i_run_byte[COUNT_BITS-1:0]) * RUN_DUR_BITS'(i_time_unit);
        n_run.kind = i_run_byte[BYTE_BITS-1];
        n_run.dur  = prod;
        n_run.nz   = (prod != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= n_run;
        end
    end

    assign o_run = r_run;

endmodule

`default_nettype wire

@@ rtl/irps_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// irps_merge: merges lane runs into pulse/space samples, one run per cycle while a packet is
// loaded and no waiting sample stalls it; depends on irps_pkg; fed by the irps_lane registers

module irps_merge #(
    parameter int NUM_RUNS = 4,
    parameter int DUR_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire irps_pkg::t_run [NUM_RUNS-1:0] i_runs,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output irps_pkg::t_out_item              o_out_item,
    output irps_pkg::t_merge_stat            o_stat
);
    import irps_pkg::*;

    localparam int STEP_BITS = (NUM_RUNS > 1) ? $clog2(NUM_RUNS) : 1;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_RUNS - 1);

    logic [STEP_BITS-1:0] r_step, n_step;
    logic [DUR_BITS-1:0]  r_pulse, n_pulse;
    logic [DUR_BITS-1:0]  r_space, n_space;
    logic                 r_open, n_open;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    t_run                 run;
    logic                 adv;
    logic                 done;
    logic                 emit;
    logic                 sp_nz;
    logic [DUR_BITS-1:0]  sample;
    logic [DUR_BITS-1:0]  dur_ext;
    logic [DUR_BITS-1:0]  sum_base;
    logic [DUR_BITS:0]    sum;
    logic [DUR_BITS-1:0]  sum_sat;
    logic                 la_open, la_sp, la_emit;
    logic [DUR_BITS+OUT_DUR_BITS-1:0] sample_wide;

    always_comb begin
        run      = i_runs[r_step];
        adv      = i_valid && (!r_out_valid || i_out_ready);
        done     = adv && (r_step == LAST_STEP);
        sp_nz    = (r_space != '0);
        dur_ext  = DUR_BITS'(run.dur);
        n_pulse  = r_pulse;
        n_space  = r_space;
        n_open   = r_open;
        emit     = 1'b0;
        sample   = r_space;
        sum_base = r_space;
        if (run.kind) begin
            emit     = sp_nz;
            sample   = r_space;
            sum_base = (r_open && !sp_nz) ? r_pulse : '0;
        end else begin
            emit     = r_open && !sp_nz;
            sample   = r_pulse;
            sum_base = r_space;
        end
        sum     = {1'b0, sum_base} + {1'b0, dur_ext};
        sum_sat = sum[DUR_BITS] ? '1 : sum[DUR_BITS-1:0];
        if (run.kind) begin
            n_space = emit ? '0 : r_space;
            n_pulse = sum_sat;
            n_open  = 1'b1;
        end else begin
            if (emit) begin
                n_open  = 1'b0;
                n_pulse = '0;
            end
            n_space = sum_sat;
        end

        // lookahead on kind and nonzero flags only: saturating sums never return to zero
        la_open = run.kind ? 1'b1 : (r_open && !emit);
        la_sp   = run.kind ? 1'b0 : (sp_nz || run.nz);
        la_emit = 1'b0;
        for (int j = 0; j < NUM_RUNS; j++) begin
            if (STEP_BITS'(j) > r_step) begin
                if (i_runs[j].kind) begin
                    la_emit = la_emit || la_sp;
                    la_sp   = 1'b0;
                    la_open = 1'b1;
                end else begin
                    la_emit = la_emit || (la_open && !la_sp);
                    la_open = la_open && la_sp;
                    la_sp   = la_sp || i_runs[j].nz;
                end
            end
        end

        sample_wide      = {{OUT_DUR_BITS{1'b0}}, sample};
        n_out.duration   = sample_wide[OUT_DUR_BITS-1:0];
        n_out.is_pulse   = run.kind ? 1'b0 : 1'b1;
        n_out.last       = !la_emit;

        n_out_valid = r_out_valid && !i_out_ready;
        if (adv && emit) begin
            n_out_valid = 1'b1;
        end
        n_step = r_step;
        if (adv) begin
            n_step = done ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_pulse     <= '0;
            r_space     <= '1;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (adv) begin
                r_pulse <= n_pulse;
                r_space <= n_space;
                r_open  <= n_open;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;
    assign o_stat.done     = done;
    assign o_stat.at_first = (r_step == '0);

endmodule

`default_nettype wire

@@ rtl/ir_pulse_space_run_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ir_pulse_space_run_decoder: top level, packet check, run lanes and merger
// depends on irps_pkg, irps_lane, irps_merge
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------
//  in       | i_in_valid / o_in_ready    | i_in_item  (irps_pkg::t_in_item)
//  out      | o_out_valid / i_out_ready  | o_out_item (irps_pkg::t_out_item)
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// the lanes scale all runs in the accepting cycle, then the merger walks one run a cycle:
// packets run back to back; a sample is registered, on the output in the cycle after its
// run's merge step, behind the lane registers and then the output register from the input
// transaction; a waiting sample holds the merger, and the last merge step frees the input
// synchronous active-low reset: time_unit 50, header 0x84, space total all ones

module ir_pulse_space_run_decoder #(
    parameter int RUNS_PER_PACKET = 4,
    parameter int DURATION_BITS   = 24
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire irps_pkg::t_in_item                  i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output irps_pkg::t_out_item                      o_out_item,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [irps_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [irps_pkg::BYTE_BITS-1:0]      i_cfg_data
);
    import irps_pkg::*;

    localparam int NUM_RUNS = (RUNS_PER_PACKET < RUN_BYTES) ? RUNS_PER_PACKET : RUN_BYTES;
    localparam logic [LEN_BITS-1:0] PKT_LEN = LEN_BITS'(RUNS_PER_PACKET + 1);

    logic [BYTE_BITS-1:0] r_time_unit;
    logic [BYTE_BITS-1:0] r_header;
    logic                 r_a_valid, n_a_valid;

    logic                          in_acc;
    logic                          pkt_ok;
    logic                          load;
    logic [BYTE_BITS-1:0]          run_bytes [RUN_BYTES];
    t_run         [NUM_RUNS-1:0]   runs;
    t_merge_stat                   stat;

    assign run_bytes[0] = i_in_item.byte1;
    assign run_bytes[1] = i_in_item.byte2;
    assign run_bytes[2] = i_in_item.byte3;
    assign run_bytes[3] = i_in_item.byte4;

    always_comb begin
        o_in_ready = !r_a_valid || stat.done;
        in_acc     = i_in_valid && o_in_ready;
        pkt_ok     = i_in_item.status_ok && (i_in_item.packet_length == PKT_LEN)
                     && (i_in_item.byte0 == r_header);
        load       = in_acc && pkt_ok;
        n_a_valid  = r_a_valid;
        if (load) begin
            n_a_valid = 1'b1;
        end else if (stat.done) begin
            n_a_valid = 1'b0;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_unit <= TIME_UNIT_RESET;
            r_header    <= HEADER_RESET;
            r_a_valid   <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_IDX_TIME_UNIT) begin
                    r_time_unit <= i_cfg_data;
                end else if (i_cfg_index == CFG_IDX_HEADER) begin
                    r_header <= i_cfg_data;
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_RUNS; g++) begin : g_lane
        irps_lane u_lane (
            .i_clk       (i_clk),
            .i_load      (load),
            .i_run_byte  (run_bytes[g]),
            .i_time_unit (r_time_unit),
            .o_run       (runs[g])
        );
    end

    irps_merge #(
        .NUM_RUNS (NUM_RUNS),
        .DUR_BITS (DURATION_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_a_valid),
        .i_runs      (runs),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_stat      (stat)
    );

    a_idle_at_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> stat.at_first)
        else $error("merger step counter away from first run with no packet");

    a_done_needs_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> r_a_valid)
        else $error("merger finished a packet that was never loaded");

    a_done_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.done && !load) |=> !r_a_valid)
        else $error("lane stage still full after its packet finished");

endmodule

`default_nettype wire

@@ tb/tb_ir_pulse_space_run_decoder.sv @@
`timescale 1ns / 1ps
// tb_ir_pulse_space_run_decoder: self-checking bench for the ir pulse/space run decoder
// predicts merged pulse/space samples per packet and compares every output transaction
// depends on irps_pkg and ir_pulse_space_run_decoder

module tb_ir_pulse_space_run_decoder;

    import irps_pkg::*;

    localparam logic [OUT_DUR_BITS-1:0] DUR_MAX       = {OUT_DUR_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]     LEN_GOOD      = LEN_BITS'(RUN_BYTES + 1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TOP   = 8'hFF;
    localparam int MAX_REPORTS   = 10;
    localparam int LONG_HOLD     = 60;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;

    class sample_scoreboard;
        logic [BYTE_BITS-1:0]    time_unit;
        logic [BYTE_BITS-1:0]    header;
        logic [OUT_DUR_BITS-1:0] pulse_sum;
        logic [OUT_DUR_BITS-1:0] space_sum;
        bit                      pulse_live;
        t_out_item               expected_samples[$];
        int errors;
        int packets_decoded;
        int packets_dropped;
        int samples_checked;
        int saturated_samples;

        function new();
            time_unit         = TIME_UNIT_RESET;
            header            = HEADER_RESET;
            pulse_sum         = '0;
            pulse_live        = 1'b0;
            space_sum         = DUR_MAX;
            errors            = 0;
            packets_decoded   = 0;
            packets_dropped   = 0;
            samples_checked   = 0;
            saturated_samples = 0;
        endfunction

        function void note_reg(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [BYTE_BITS-1:0] val);
            case (idx)
                CFG_IDX_TIME_UNIT: time_unit = val;
                CFG_IDX_HEADER:    header = val;
                default: ;
            endcase
        endfunction

        function logic [OUT_DUR_BITS-1:0] sat_sum(input logic [OUT_DUR_BITS-1:0] a,
                                                  input logic [RUN_DUR_BITS-1:0] b);
            logic [OUT_DUR_BITS:0] s;
            s = {1'b0, a} + (OUT_DUR_BITS+1)'(b);
            return (s > DUR_MAX) ? DUR_MAX : s[OUT_DUR_BITS-1:0];
        endfunction

        function void push_sample(input logic [OUT_DUR_BITS-1:0] dur, input logic pulse);
            t_out_item e;
            e.duration = dur;
            e.is_pulse = pulse;
            e.last     = 1'b0;
            expected_samples.push_back(e);
        endfunction

        function void note_packet(input t_in_item p);
            logic [BYTE_BITS-1:0]    runs [RUN_BYTES];
            logic [RUN_DUR_BITS-1:0] dur;
            t_out_item               tail;
            int                      produced;
            if (!p.status_ok || p.packet_length != LEN_GOOD || p.byte0 != header) begin
                packets_dropped++;
                return;
            end
            packets_decoded++;
            produced = 0;
            runs = '{p.byte1, p.byte2, p.byte3, p.byte4};
            for (int i = 0; i < RUN_BYTES; i++) begin
                dur = RUN_DUR_BITS'(runs[i][COUNT_BITS-1:0]) * RUN_DUR_BITS'(time_unit);
                if (runs[i][BYTE_BITS-1]) begin
                    if (space_sum != '0) begin
                        push_sample(space_sum, 1'b0);
                        produced++;
                        space_sum  = '0;
                        pulse_live = 1'b0;
                    end
                    if (!pulse_live) begin
                        pulse_sum = '0;
                    end
                    pulse_sum  = sat_sum(pulse_sum, dur);
                    pulse_live = 1'b1;
                end else begin
                    if (pulse_live && space_sum == '0) begin
                        push_sample(pulse_sum, 1'b1);
                        produced++;
                        pulse_live = 1'b0;
                        pulse_sum  = '0;
                    end
                    space_sum = sat_sum(space_sum, dur);
                end
            end
            if (produced > 0) begin
                tail = expected_samples.pop_back();
                tail.last = 1'b1;
                expected_samples.push_back(tail);
            end
        endfunction

        function void check_sample(input t_out_item got);
            t_out_item want;
            samples_checked++;
            if (got.duration == DUR_MAX) begin
                saturated_samples++;
            end
            if (expected_samples.size() == 0) begin
                if (errors < MAX_REPORTS) begin
                    $display("unexpected sample: duration %0d pulse %0b last %0b",
                             got.duration, got.is_pulse, got.last);
                end
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (got.duration !== want.duration || got.is_pulse !== want.is_pulse ||
                got.last !== want.last) begin
                if (errors < MAX_REPORTS) begin
                    $display("sample %0d: expected duration %0d pulse %0b last %0b, got %0d %0b %0b",
                             samples_checked, want.duration, want.is_pulse, want.last,
                             got.duration, got.is_pulse, got.last);
                end
                errors++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    t_in_item                i_in_item   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_out_item               o_out_item;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [BYTE_BITS-1:0]    i_cfg_data  = '0;

    sample_scoreboard sb;
    bit idling       = 1'b1;
    bit hold_request = 1'b0;
    int settings     = 0;

    ir_pulse_space_run_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // output side: check each transaction, then pick next cycle's ready
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                sb.check_sample(o_out_item);
            end
            if (hold_request) begin
                stall_left   = LONG_HOLD;
                hold_request = 1'b0;
            end else if (stall_left == 0 && idling && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_item pkt(input logic st, input logic [LEN_BITS-1:0] len,
                                     input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3,
                                     input logic [7:0] b4);
        t_in_item p;
        p.status_ok     = st;
        p.packet_length = len;
        p.byte0         = b0;
        p.byte1         = b1;
        p.byte2         = b2;
        p.byte3         = b3;
        p.byte4         = b4;
        return p;
    endfunction

    function automatic logic [BYTE_BITS-1:0] random_run();
        logic [BYTE_BITS-1:0] b;
        b = BYTE_BITS'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: b[COUNT_BITS-1:0] = '0;
            1: b[COUNT_BITS-1:0] = '1;
            default: ;
        endcase
        return b;
    endfunction

    // mostly well-formed run packets, the rest bad status, length, header or junk
    function automatic t_in_item random_packet(input logic [BYTE_BITS-1:0] hdr);
        t_in_item p;
        p = pkt(1'b1, LEN_GOOD, hdr, random_run(), random_run(), random_run(), random_run());
        case ($urandom_range(0, 15))
            0: p.status_ok = 1'b0;
            1: p.packet_length = LEN_BITS'($urandom_range(0, 127));
            2: p.byte0 = BYTE_BITS'($urandom_range(0, 255));
            3: begin
                p.status_ok     = 1'($urandom_range(0, 1));
                p.packet_length = LEN_BITS'($urandom_range(0, 127));
                p.byte0         = BYTE_BITS'($urandom_range(0, 255));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_packet(input t_in_item p);
        i_in_valid <= 1'b1;
        i_in_item  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_packet(p);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [BYTE_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_reg(idx, val);
    endtask

    task automatic set_regs(input logic [BYTE_BITS-1:0] tu, input logic [BYTE_BITS-1:0] hdr);
        wait_drained();
        write_reg(CFG_IDX_TIME_UNIT, tu);
        write_reg(CFG_IDX_HEADER, hdr);
        write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE : CFG_IDX_TOP,
                  BYTE_BITS'($urandom_range(0, 255)));
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: dropped packets, then pulse/space merging cases
        send_packet(pkt(1'b0, LEN_GOOD, 8'h84, 8'h81, 8'h01, 8'h81, 8'h01));
        send_packet(pkt(1'b1, 7'd4, 8'h84, 8'h81, 8'h01, 8'h81, 8'h01));
        send_packet(pkt(1'b1, 7'h7F, 8'h84, 8'h81, 8'h01, 8'h81, 8'h01));
        send_packet(pkt(1'b1, 7'd0, 8'h84, 8'h81, 8'h01, 8'h81, 8'h01));
        send_packet(pkt(1'b1, LEN_GOOD, 8'h85, 8'h81, 8'h01, 8'h81, 8'h01));
        send_packet(pkt(1'b1, LEN_GOOD, 8'h84, 8'h7F, 8'h00, 8'h7F, 8'h05));
        send_packet(pkt(1'b1, LEN_GOOD, 8'h84, 8'h8A, 8'h85, 8'h80, 8'hFF));
        send_packet(pkt(1'b1, LEN_GOOD, 8'h84, 8'h00, 8'h85, 8'h03, 8'h81));
        send_packet(pkt(1'b1, LEN_GOOD, 8'h84, 8'h80, 8'h00, 8'h80, 8'h00));
        send_packet(pkt(1'b1, LEN_GOOD, 8'h84, 8'h81, 8'h01, 8'h81, 8'h01));
        send_packet(pkt(1'b1, LEN_GOOD, 8'h84, 8'hFF, 8'h7F, 8'hFF, 8'h7F));
        send_packet(pkt(1'b1, LEN_GOOD, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00));

        set_regs(8'd255, 8'hFF);
        send_packet(pkt(1'b1, LEN_GOOD, 8'h84, 8'hFF, 8'h7F, 8'hFF, 8'h7F));
        send_packet(pkt(1'b1, LEN_GOOD, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h7F));
        send_packet(pkt(1'b1, LEN_GOOD, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'h80));

        set_regs(8'd0, 8'h00);
        send_packet(pkt(1'b1, LEN_GOOD, 8'h00, 8'hFF, 8'h7F, 8'h81, 8'h01));
        send_packet(pkt(1'b1, LEN_GOOD, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00));

        set_regs(8'd1, HEADER_RESET);
        send_packet(pkt(1'b1, LEN_GOOD, 8'h84, 8'h81, 8'h7F, 8'hFF, 8'h00));

        for (int ph = 0; ph < 4; ph++) begin
            set_regs(BYTE_BITS'($urandom_range(1, 255)), BYTE_BITS'($urandom_range(0, 255)));
            idling = (ph != 3) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 20; k++) begin
                if (ph == 0 && k == 10) begin
                    idling = ~idling;
                end
                if (ph == 1 && k == 4) begin
                    idling       = 1'b0;
                    hold_request = 1'b1;
                end
                if (ph == 1 && k == 16) begin
                    idling = 1'b1;
                end
                if (ph == 2 && k == 10) begin
                    wait_drained();
                end
                send_packet(random_packet(sb.header));
            end
        end

        wait_drained();
        if (sb.pending() != 0) begin
            $display("%0d expected samples never arrived", sb.pending());
            sb.errors += sb.pending();
        end
        $display("packets: %0d decoded, %0d dropped; samples checked: %0d (%0d saturated)",
                 sb.packets_decoded, sb.packets_dropped, sb.samples_checked,
                 sb.saturated_samples);
        $display("register settings: %0d, time unit 0/1/255 and header 0x00/0xFF among them",
                 settings);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/irps_pkg.sv
rtl/irps_lane.sv
rtl/irps_merge.sv
rtl/ir_pulse_space_run_decoder.sv
tb/tb_ir_pulse_space_run_decoder.sv
